FILE: sv/lpfm_pkg.sv
// Shared types, command codes and status codes of the LRU page frame manager.
package lpfm_pkg;

  localparam int unsigned IDX_W  = 6;
  localparam int unsigned FILE_W = 16;
  localparam int unsigned PAGE_W = 32;
  localparam int unsigned CFG_W  = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd16;

  localparam logic [2:0] CMD_ALLOC      = 3'd0;
  localparam logic [2:0] CMD_LOOKUP     = 3'd1;
  localparam logic [2:0] CMD_DISP_PAGE  = 3'd2;
  localparam logic [2:0] CMD_DISP_FRAME = 3'd3;
  localparam logic [2:0] CMD_FLUSH      = 3'd4;
  localparam logic [2:0] CMD_PIN        = 3'd5;
  localparam logic [2:0] CMD_UNPIN      = 3'd6;
  localparam logic [2:0] CMD_DIRTY      = 3'd7;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_MISS      = 2'd1;
  localparam logic [1:0] STAT_NO_VICTIM = 2'd2;
  localparam logic [1:0] STAT_REFUSED   = 2'd3;

  typedef struct packed {
    logic [2:0]        command;
    logic [FILE_W-1:0] file_id;
    logic [PAGE_W-1:0] page_number;
    logic [IDX_W-1:0]  frame_index;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  result_frame;
    logic              writeback_valid;
    logic [FILE_W-1:0] writeback_file;
    logic [PAGE_W-1:0] writeback_page;
    logic [IDX_W-1:0]  writeback_frame;
    logic              last;
  } out_t;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_ALLOC,
    UPD_TOUCH,
    UPD_FREE,
    UPD_FLUSH,
    UPD_PIN,
    UPD_UNPIN,
    UPD_DIRTY
  } upd_op_e;

  typedef struct packed {
    upd_op_e           op;
    logic [IDX_W-1:0]  tgt;
    logic [IDX_W-1:0]  rank;
    logic [FILE_W-1:0] file;
    logic [PAGE_W-1:0] page;
    logic [CFG_W-1:0]  live;
  } upd_t;

  typedef struct packed {
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] free_rank;
    logic             vic_found;
    logic [IDX_W-1:0] vic_idx;
    logic [IDX_W-1:0] vic_rank;
    logic             hit_found;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] hit_rank;
  } token_t;

  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic              pin_nz;
    logic [FILE_W-1:0] tag_file;
    logic [PAGE_W-1:0] tag_page;
  } view_t;

endpackage

FILE: sv/lru_page_frame_manager.sv
// Top level of the LRU page frame manager: request sequencer, cell row and result register.
// Allocate, lookup and dispose page issue their result once the search token has walked
// the cell row one cell a cycle; pin, unpin, dirty and dispose frame need no search.
// Flush file issues at most one writeback per cycle, none while the output is stalled.
// One request is in progress at a time; the next is taken once its final result is issued.
// Reset is asynchronous and active low: all frames free, pins and dirty marks cleared,
// recency in frame index order and active_frames at 16, with no clearing pass.
module lru_page_frame_manager #(
  parameter int unsigned FRAMES   = 16,
  parameter int unsigned PIN_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lpfm_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lpfm_pkg::out_t               out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lpfm_pkg::CFG_W-1:0]   cfg_data_i
);
  import lpfm_pkg::*;

  localparam int unsigned IW = $clog2(FRAMES);
  localparam int unsigned CW = $clog2(FRAMES + 1);
  localparam logic [CFG_W-1:0] FRAMES_C = CFG_W'(FRAMES);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SWEEP   = 3'd1;
  localparam logic [2:0] ST_EXEC    = 3'd2;
  localparam logic [2:0] ST_FLSTART = 3'd3;
  localparam logic [2:0] ST_FLSCAN  = 3'd4;

  logic [CFG_W-1:0]  active_q;
  logic [CFG_W-1:0]  live;
  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [FRAMES-1:0] wbmask_q, wbmask_d;
  in_t               req_q, req_d;
  out_t              out_q, res;
  logic              out_valid_q, emit, out_free, fi_in;
  upd_t              upd;
  token_t            tok [FRAMES+1];
  view_t             view [FRAMES];
  view_t             fv, vv, hv, sv;
  logic [IW-1:0]     fsel, ssel;
  logic [FRAMES-1:0] fl_wb;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (active_q == '0) begin
      live = CFG_W'(1);
    end else if (active_q > FRAMES_C) begin
      live = FRAMES_C;
    end else begin
      live = active_q;
    end
  end

  assign tok[0] = '0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lpfm_cell #(
      .FRAMES  (FRAMES),
      .INDEX   (g),
      .PIN_BITS(PIN_BITS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .upd_i (upd),
      .tok_i (tok[g]),
      .tok_o (tok[g+1]),
      .view_o(view[g])
    );
  end

  assign fi_in = {1'b0, req_q.frame_index} < live;
  assign fsel  = req_q.frame_index[IW-1:0];
  assign ssel  = cnt_q[IW-1:0];
  assign fv    = view[fsel];
  assign sv    = view[ssel];
  assign vv    = view[tok[FRAMES].vic_idx[IW-1:0]];
  assign hv    = view[tok[FRAMES].hit_idx[IW-1:0]];

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      fl_wb[i] = (CFG_W'(i) < live) && view[i].valid && view[i].dirty &&
                 (view[i].tag_file == req_q.file_id);
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = state_q == ST_IDLE;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    wbmask_d = wbmask_q;
    req_d    = req_q;
    emit     = 1'b0;
    res      = '0;
    res.last = 1'b1;
    upd.op   = UPD_NONE;
    upd.tgt  = '0;
    upd.rank = '0;
    upd.file = req_q.file_id;
    upd.page = req_q.page_number;
    upd.live = live;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          cnt_d = '0;
          case (in_data_i.command)
            CMD_ALLOC, CMD_LOOKUP, CMD_DISP_PAGE: state_d = ST_SWEEP;
            CMD_FLUSH: state_d = ST_FLSTART;
            default: state_d = ST_EXEC;
          endcase
        end
      end
      ST_SWEEP: begin
        if (cnt_q != CW'(FRAMES)) begin
          cnt_d = cnt_q + CW'(1);
        end else if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
          case (req_q.command)
            CMD_ALLOC: begin
              if (tok[FRAMES].free_found) begin
                res.result_frame = tok[FRAMES].free_idx;
                upd.op   = UPD_ALLOC;
                upd.tgt  = tok[FRAMES].free_idx;
                upd.rank = tok[FRAMES].free_rank;
              end else if (tok[FRAMES].vic_found) begin
                res.result_frame = tok[FRAMES].vic_idx;
                if (vv.dirty) begin
                  res.writeback_valid = 1'b1;
                  res.writeback_file  = vv.tag_file;
                  res.writeback_page  = vv.tag_page;
                  res.writeback_frame = tok[FRAMES].vic_idx;
                end
                upd.op   = UPD_ALLOC;
                upd.tgt  = tok[FRAMES].vic_idx;
                upd.rank = tok[FRAMES].vic_rank;
              end else begin
                res.status = STAT_NO_VICTIM;
              end
            end
            CMD_LOOKUP: begin
              if (tok[FRAMES].hit_found) begin
                res.result_frame = tok[FRAMES].hit_idx;
                upd.op   = UPD_TOUCH;
                upd.tgt  = tok[FRAMES].hit_idx;
                upd.rank = tok[FRAMES].hit_rank;
              end else begin
                res.status = STAT_MISS;
              end
            end
            default: begin
              if (tok[FRAMES].hit_found) begin
                res.result_frame = tok[FRAMES].hit_idx;
                if (hv.pin_nz) begin
                  res.status = STAT_REFUSED;
                end else begin
                  upd.op  = UPD_FREE;
                  upd.tgt = tok[FRAMES].hit_idx;
                end
              end
            end
          endcase
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
          if (req_q.command == CMD_DISP_FRAME) begin
            if (!fi_in) begin
              res.status = STAT_MISS;
            end else if (fv.pin_nz) begin
              res.status       = STAT_REFUSED;
              res.result_frame = req_q.frame_index;
            end else begin
              res.result_frame = req_q.frame_index;
              if (fv.valid && fv.dirty) begin
                res.writeback_valid = 1'b1;
                res.writeback_file  = fv.tag_file;
                res.writeback_page  = fv.tag_page;
                res.writeback_frame = req_q.frame_index;
              end
              upd.op  = UPD_FREE;
              upd.tgt = req_q.frame_index;
            end
          end else if (!fi_in || !fv.valid) begin
            res.status = STAT_MISS;
          end else begin
            res.result_frame = req_q.frame_index;
            upd.tgt          = req_q.frame_index;
            case (req_q.command)
              CMD_PIN:   upd.op = UPD_PIN;
              CMD_UNPIN: upd.op = UPD_UNPIN;
              default:   upd.op = UPD_DIRTY;
            endcase
          end
        end
      end
      ST_FLSTART: begin
        wbmask_d = fl_wb;
        upd.op   = UPD_FLUSH;
        cnt_d    = '0;
        state_d  = ST_FLSCAN;
      end
      ST_FLSCAN: begin
        if (cnt_q == CW'(FRAMES)) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (wbmask_q[ssel]) begin
          if (out_free) begin
            emit                = 1'b1;
            res.last            = 1'b0;
            res.result_frame    = IDX_W'(ssel);
            res.writeback_valid = 1'b1;
            res.writeback_file  = sv.tag_file;
            res.writeback_page  = sv.tag_page;
            res.writeback_frame = IDX_W'(ssel);
            cnt_d               = cnt_q + CW'(1);
          end
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= CFG_RESET;
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      wbmask_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        active_q <= cfg_data_i;
      end
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      wbmask_q <= wbmask_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/lpfm_cell.sv
// One page frame cell: frame state, local update and one stage of the search chain.
module lpfm_cell #(
  parameter int unsigned FRAMES   = 16,
  parameter int unsigned INDEX    = 0,
  parameter int unsigned PIN_BITS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lpfm_pkg::upd_t   upd_i,
  input  lpfm_pkg::token_t tok_i,
  output lpfm_pkg::token_t tok_o,
  output lpfm_pkg::view_t  view_o
);
  import lpfm_pkg::*;

  localparam int unsigned RW = $clog2(FRAMES);
  localparam logic [IDX_W-1:0] MY = IDX_W'(INDEX);
  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

  logic              valid_q, valid_d;
  logic              mapped_q, mapped_d;
  logic              dirty_q, dirty_d;
  logic [PIN_BITS-1:0] pin_q, pin_d;
  logic [RW-1:0]     rank_q, rank_d;
  logic [FILE_W-1:0] tf_q;
  logic [PAGE_W-1:0] tp_q;
  token_t            tok_q, tok_d;
  logic              act, tag_hit, is_tgt;
  logic [IDX_W-1:0]  rank6;

  assign act     = {1'b0, MY} < upd_i.live;
  assign tag_hit = (tf_q == upd_i.file) && (tp_q == upd_i.page);
  assign is_tgt  = MY == upd_i.tgt;
  assign rank6   = IDX_W'(rank_q);

  always_comb begin
    tok_d = tok_i;
    if (!tok_i.free_found && act && !valid_q) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = MY;
      tok_d.free_rank  = rank6;
    end
    if (act && (pin_q == '0) && (!tok_i.vic_found || (rank6 > tok_i.vic_rank))) begin
      tok_d.vic_found = 1'b1;
      tok_d.vic_idx   = MY;
      tok_d.vic_rank  = rank6;
    end
    if (!tok_i.hit_found && act && valid_q && mapped_q && tag_hit) begin
      tok_d.hit_found = 1'b1;
      tok_d.hit_idx   = MY;
      tok_d.hit_rank  = rank6;
    end
  end

  always_comb begin
    valid_d  = valid_q;
    mapped_d = mapped_q;
    dirty_d  = dirty_q;
    pin_d    = pin_q;
    rank_d   = rank_q;
    case (upd_i.op)
      UPD_ALLOC, UPD_TOUCH: begin
        if (upd_i.op == UPD_ALLOC) begin
          if (act && mapped_q && tag_hit) begin
            mapped_d = 1'b0;
          end
          if (is_tgt) begin
            valid_d  = 1'b1;
            mapped_d = 1'b1;
            dirty_d  = 1'b0;
            pin_d    = '0;
          end
        end
        if (is_tgt) begin
          rank_d = '0;
        end else if (rank6 < upd_i.rank) begin
          rank_d = rank_q + RW'(1);
        end
      end
      UPD_FREE: begin
        if (is_tgt) begin
          valid_d  = 1'b0;
          mapped_d = 1'b0;
          dirty_d  = 1'b0;
        end
      end
      UPD_FLUSH: begin
        if (act && valid_q && (tf_q == upd_i.file)) begin
          valid_d  = 1'b0;
          mapped_d = 1'b0;
          dirty_d  = 1'b0;
          pin_d    = '0;
        end
      end
      UPD_PIN: begin
        if (is_tgt && (pin_q != PIN_MAX)) begin
          pin_d = pin_q + PIN_BITS'(1);
        end
      end
      UPD_UNPIN: begin
        if (is_tgt && (pin_q != '0)) begin
          pin_d = pin_q - PIN_BITS'(1);
        end
      end
      UPD_DIRTY: begin
        if (is_tgt) begin
          dirty_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      mapped_q <= 1'b0;
      dirty_q  <= 1'b0;
      pin_q    <= '0;
      rank_q   <= RW'(INDEX);
      tok_q    <= '0;
    end else begin
      valid_q  <= valid_d;
      mapped_q <= mapped_d;
      dirty_q  <= dirty_d;
      pin_q    <= pin_d;
      rank_q   <= rank_d;
      tok_q    <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((upd_i.op == UPD_ALLOC) && is_tgt) begin
      tf_q <= upd_i.file;
      tp_q <= upd_i.page;
    end
  end

  assign tok_o           = tok_q;
  assign view_o.valid    = valid_q;
  assign view_o.dirty    = dirty_q;
  assign view_o.pin_nz   = pin_q != '0;
  assign view_o.tag_file = tf_q;
  assign view_o.tag_page = tp_q;

endmodule

FILE: sv/lpfm_checker.sv
// Port-level assertions of the LRU page frame manager and the bind that attaches them.
module lpfm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input lpfm_pkg::out_t out_data_o
);
  import lpfm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Result changed or vanished while stalled.");

  a_wb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.writeback_valid |->
      out_data_o.writeback_file == '0 && out_data_o.writeback_page == '0 &&
      out_data_o.writeback_frame == '0)
    else $error("Writeback fields set without a writeback request.");

  a_mid_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |->
      out_data_o.writeback_valid && out_data_o.status == STAT_OK &&
      out_data_o.writeback_frame == out_data_o.result_frame)
    else $error("Non-final result is not a flush writeback.");

  a_fail_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STAT_OK |-> !out_data_o.writeback_valid)
    else $error("Failed request carries a writeback.");

endmodule

bind lru_page_frame_manager lpfm_checker u_lpfm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench of the LRU page frame manager with its own model of the frame table.
module tb_top;
  import lpfm_pkg::*;

  localparam int unsigned FRAMES   = 16;
  localparam int unsigned PIN_BITS = 8;
  localparam int unsigned PIN_MAX  = (1 << PIN_BITS) - 1;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_LEN = 400;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  in_t              in_data_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_t             out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i = '0;

  lru_page_frame_manager #(.FRAMES(FRAMES), .PIN_BITS(PIN_BITS)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Model of the frame table.
  logic             fr_valid [FRAMES];
  logic             fr_mapped[FRAMES];
  logic             fr_dirty [FRAMES];
  logic [15:0]      fr_file  [FRAMES];
  logic [31:0]      fr_page  [FRAMES];
  int unsigned      fr_pins  [FRAMES];
  int unsigned      fr_rank  [FRAMES];
  logic [CFG_W-1:0] active_frames = CFG_RESET;

  out_t        expected_results[$];
  int unsigned fail_count = 0;
  int unsigned snd_idle = 0;
  int unsigned rcv_idle = 0;
  int unsigned hold_cycles = 0;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned quiet_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned live_frames();
    if (active_frames == 0) return 1;
    if (active_frames > FRAMES) return FRAMES;
    return 32'(active_frames);
  endfunction

  function automatic out_t make_result(logic [1:0] st, int unsigned fr, logic wb,
                                       int unsigned wf, logic lst);
    out_t r;
    r.status          = st;
    r.result_frame    = fr[IDX_W-1:0];
    r.writeback_valid = wb;
    r.writeback_file  = wb ? fr_file[wf] : '0;
    r.writeback_page  = wb ? fr_page[wf] : '0;
    r.writeback_frame = wb ? wf[IDX_W-1:0] : '0;
    r.last            = lst;
    return r;
  endfunction

  function automatic void make_recent(int unsigned f);
    int unsigned r;
    r = fr_rank[f];
    for (int i = 0; i < FRAMES; i++) if (fr_rank[i] < r) fr_rank[i]++;
    fr_rank[f] = 0;
  endfunction

  function automatic int find_page(logic [15:0] file, logic [31:0] page);
    for (int i = 0; i < live_frames(); i++)
      if (fr_valid[i] && fr_mapped[i] && fr_file[i] == file && fr_page[i] == page) return i;
    return -1;
  endfunction

  function automatic void free_frame(int unsigned f);
    fr_valid[f]  = 1'b0;
    fr_mapped[f] = 1'b0;
    fr_dirty[f]  = 1'b0;
  endfunction

  task automatic predict_request(in_t rq);
    int unsigned n;
    int unsigned fi;
    int pick;
    int unsigned best;
    logic wb;
    n    = live_frames();
    fi   = 32'(rq.frame_index);
    pick = -1;
    best = 0;
    wb   = 1'b0;
    case (rq.command)
      CMD_ALLOC: begin
        for (int i = 0; i < n && pick < 0; i++) if (!fr_valid[i]) pick = i;
        if (pick < 0) begin
          for (int i = 0; i < n; i++)
            if (fr_pins[i] == 0 && (pick < 0 || fr_rank[i] > best)) begin
              pick = i;
              best = fr_rank[i];
            end
          if (pick >= 0) wb = fr_dirty[pick];
        end
        if (pick < 0) begin
          expected_results.push_back(make_result(STAT_NO_VICTIM, 0, 1'b0, 0, 1'b1));
        end else begin
          expected_results.push_back(make_result(STAT_OK, pick, wb, pick, 1'b1));
          for (int i = 0; i < n; i++)
            if (fr_mapped[i] && fr_file[i] == rq.file_id && fr_page[i] == rq.page_number)
              fr_mapped[i] = 1'b0;
          fr_valid[pick]  = 1'b1;
          fr_mapped[pick] = 1'b1;
          fr_dirty[pick]  = 1'b0;
          fr_pins[pick]   = 0;
          fr_file[pick]   = rq.file_id;
          fr_page[pick]   = rq.page_number;
          make_recent(pick);
        end
      end
      CMD_LOOKUP: begin
        pick = find_page(rq.file_id, rq.page_number);
        if (pick < 0) begin
          expected_results.push_back(make_result(STAT_MISS, 0, 1'b0, 0, 1'b1));
        end else begin
          make_recent(pick);
          expected_results.push_back(make_result(STAT_OK, pick, 1'b0, 0, 1'b1));
        end
      end
      CMD_DISP_PAGE: begin
        pick = find_page(rq.file_id, rq.page_number);
        if (pick < 0) begin
          expected_results.push_back(make_result(STAT_OK, 0, 1'b0, 0, 1'b1));
        end else if (fr_pins[pick] != 0) begin
          expected_results.push_back(make_result(STAT_REFUSED, pick, 1'b0, 0, 1'b1));
        end else begin
          free_frame(pick);
          expected_results.push_back(make_result(STAT_OK, pick, 1'b0, 0, 1'b1));
        end
      end
      CMD_DISP_FRAME: begin
        if (fi >= n) begin
          expected_results.push_back(make_result(STAT_MISS, 0, 1'b0, 0, 1'b1));
        end else if (fr_pins[fi] != 0) begin
          expected_results.push_back(make_result(STAT_REFUSED, fi, 1'b0, 0, 1'b1));
        end else begin
          wb = fr_valid[fi] && fr_dirty[fi];
          expected_results.push_back(make_result(STAT_OK, fi, wb, fi, 1'b1));
          free_frame(fi);
        end
      end
      CMD_FLUSH: begin
        for (int i = 0; i < n; i++) begin
          if (fr_valid[i] && fr_file[i] == rq.file_id) begin
            if (fr_dirty[i])
              expected_results.push_back(make_result(STAT_OK, i, 1'b1, i, 1'b0));
            free_frame(i);
            fr_pins[i] = 0;
          end
        end
        expected_results.push_back(make_result(STAT_OK, 0, 1'b0, 0, 1'b1));
      end
      default: begin
        if (fi >= n || !fr_valid[fi]) begin
          expected_results.push_back(make_result(STAT_MISS, 0, 1'b0, 0, 1'b1));
        end else begin
          if (rq.command == CMD_PIN) begin
            if (fr_pins[fi] < PIN_MAX) fr_pins[fi]++;
          end else if (rq.command == CMD_UNPIN) begin
            if (fr_pins[fi] > 0) fr_pins[fi]--;
          end else begin
            fr_dirty[fi] = 1'b1;
          end
          expected_results.push_back(make_result(STAT_OK, fi, 1'b0, 0, 1'b1));
        end
      end
    endcase
  endtask

  task automatic send_request(in_t rq);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle && gap < 40) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= rq;
    do @(posedge clk_i); while (!in_ready_o);
    predict_request(rq);
  endtask

  task automatic send_cmd(logic [2:0] cmd, logic [15:0] file, logic [31:0] page,
                          logic [5:0] idx);
    in_t rq;
    rq.command     = cmd;
    rq.file_id     = file;
    rq.page_number = page;
    rq.frame_index = idx;
    send_request(rq);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (FRAMES + 4) @(posedge clk_i);
  endtask

  task automatic write_active_frames(logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    active_frames = value;
  endtask

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_cycles <= HOLD_LEN;
      out_ready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result 0x%0h", out_data_o);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        check_field("status", 32'(e.status), 32'(out_data_o.status));
        check_field("result_frame", 32'(e.result_frame), 32'(out_data_o.result_frame));
        check_field("writeback_valid", 32'(e.writeback_valid),
                    32'(out_data_o.writeback_valid));
        check_field("writeback_file", 32'(e.writeback_file), 32'(out_data_o.writeback_file));
        check_field("writeback_page", e.writeback_page, out_data_o.writeback_page);
        check_field("writeback_frame", 32'(e.writeback_frame),
                    32'(out_data_o.writeback_frame));
        check_field("last", 32'(e.last), 32'(out_data_o.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[lru_page_frame_manager] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic directed_test();
    send_cmd(CMD_LOOKUP, 16'h0, 32'h0, 6'd0);
    send_cmd(CMD_ALLOC, 16'h0, 32'h0, 6'd0);
    send_cmd(CMD_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 6'd63);
    send_cmd(CMD_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 6'd0);
    send_cmd(CMD_ALLOC, 16'h0, 32'h0, 6'd0);
    send_cmd(CMD_LOOKUP, 16'h0, 32'h0, 6'd0);
    send_cmd(CMD_DIRTY, 16'h0, 32'h0, 6'd2);
    send_cmd(CMD_DIRTY, 16'h0, 32'h0, 6'd1);
    send_cmd(CMD_PIN, 16'h0, 32'h0, 6'd1);
    send_cmd(CMD_DISP_PAGE, 16'hFFFF, 32'hFFFF_FFFF, 6'd0);
    send_cmd(CMD_DISP_FRAME, 16'h0, 32'h0, 6'd1);
    send_cmd(CMD_UNPIN, 16'h0, 32'h0, 6'd1);
    send_cmd(CMD_UNPIN, 16'h0, 32'h0, 6'd1);
    send_cmd(CMD_DISP_PAGE, 16'hFFFF, 32'hFFFF_FFFF, 6'd0);
    send_cmd(CMD_DISP_PAGE, 16'h1234, 32'h5678, 6'd0);
    send_cmd(CMD_DISP_FRAME, 16'h0, 32'h0, 6'd63);
    send_cmd(CMD_DISP_FRAME, 16'h0, 32'h0, 6'd2);
    send_cmd(CMD_PIN, 16'h0, 32'h0, 6'd9);
    send_cmd(CMD_DIRTY, 16'h0, 32'h0, 6'd63);
    send_cmd(CMD_FLUSH, 16'h0, 32'h0, 6'd0);
    // Fill every frame with dirty pages of one file, then evict and flush.
    for (int i = 0; i < FRAMES; i++) begin
      send_cmd(CMD_ALLOC, 16'h00A5, 32'(i), 6'd0);
      send_cmd(CMD_DIRTY, 16'h0, 32'h0, 6'(i));
    end
    send_cmd(CMD_ALLOC, 16'h5A00, 32'h8000_0000, 6'd0);
    send_cmd(CMD_FLUSH, 16'h00A5, 32'h0, 6'd0);
    // With every frame valid and pinned there is no victim.
    for (int i = 0; i < FRAMES; i++) begin
      send_cmd(CMD_ALLOC, 16'h0077, 32'(i), 6'd0);
      send_cmd(CMD_PIN, 16'h0, 32'h0, 6'(i));
    end
    send_cmd(CMD_ALLOC, 16'h0078, 32'h1, 6'd0);
    send_cmd(CMD_FLUSH, 16'h0077, 32'h0, 6'd0);
  endtask

  task automatic pin_saturation_test();
    send_cmd(CMD_ALLOC, 16'h0033, 32'h33, 6'd0);
    repeat (PIN_MAX + 1) send_cmd(CMD_PIN, 16'h0, 32'h0, 6'd0);
    send_cmd(CMD_DISP_FRAME, 16'h0, 32'h0, 6'd0);
    send_cmd(CMD_UNPIN, 16'h0, 32'h0, 6'd0);
    send_cmd(CMD_DISP_FRAME, 16'h0, 32'h0, 6'd0);
    send_cmd(CMD_FLUSH, 16'h0033, 32'h0, 6'd0);
  endtask

  task automatic random_test(int unsigned count);
    in_t rq;
    int unsigned w;
    for (int k = 0; k < count; k++) begin
      w = $urandom_range(99);
      if (w < 30)      rq.command = CMD_ALLOC;
      else if (w < 50) rq.command = CMD_LOOKUP;
      else if (w < 58) rq.command = CMD_DIRTY;
      else if (w < 68) rq.command = CMD_PIN;
      else if (w < 78) rq.command = CMD_UNPIN;
      else if (w < 86) rq.command = CMD_DISP_PAGE;
      else if (w < 94) rq.command = CMD_DISP_FRAME;
      else             rq.command = CMD_FLUSH;
      if ($urandom_range(19) == 0) begin
        rq.file_id     = 16'($urandom);
        rq.page_number = $urandom;
        rq.frame_index = 6'($urandom);
      end else begin
        rq.file_id     = 16'($urandom_range(3) * 16'h5555);
        rq.page_number = {1'($urandom_range(1)), 26'd0, 5'($urandom_range(23))};
        rq.frame_index = 6'($urandom_range(live_frames() + 1));
      end
      send_request(rq);
    end
  endtask

  task automatic backpressure_test();
    hold_req = ~hold_req;
    random_test(8);
    wait_drain();
  endtask

  task automatic config_phase(logic [CFG_W-1:0] value, int unsigned count);
    wait_drain();
    write_active_frames(value);
    random_test(count);
  endtask

  initial begin
    for (int i = 0; i < FRAMES; i++) begin
      fr_valid[i]  = 1'b0;
      fr_mapped[i] = 1'b0;
      fr_dirty[i]  = 1'b0;
      fr_file[i]   = '0;
      fr_page[i]   = '0;
      fr_pins[i]   = 0;
      fr_rank[i]   = i;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    snd_idle = 14;
    rcv_idle = 88;
    directed_test();
    pin_saturation_test();
    config_phase(7'd16, 12);
    backpressure_test();
    snd_idle = 88;
    rcv_idle = 14;
    config_phase(7'd0, 12);
    config_phase(7'd127, 12);
    snd_idle = 0;
    rcv_idle = 0;
    config_phase(7'd1, 8);
    config_phase(7'd5, 10);
    config_phase(7'd64, 12);
    wait_drain();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("[lru_page_frame_manager] OK");
    end else begin
      $display("[lru_page_frame_manager] ERROR");
    end
    $finish;
  end

endmodule
